// ===== design/deaa_pkg.sv =====
`default_nettype none
package deaa_pkg;

  localparam int DATA_W  = 25;
  localparam int ALIGN_W = 4;
  // room for cursor plus alignment padding plus request size
  localparam int CALC_W  = DATA_W + 2;

  localparam logic [DATA_W-1:0] CAP_RESET = DATA_W'(1048576);

  typedef enum logic [1:0] {
    OP_ALLOC_LOW  = 2'd0,
    OP_ALLOC_HIGH = 2'd1,
    OP_RESET_ALL  = 2'd2,
    OP_RESET_HIGH = 2'd3
  } op_t;

  typedef struct packed {
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] high;
    logic [DATA_W-1:0] peak;
  } cursors_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] offset;
    cursors_t          cur;
  } step_res_t;

endpackage
`default_nettype wire

// ===== design/deaa_if.sv =====
`default_nettype none
interface deaa_req_if;
  logic                             valid;
  logic                             ready;
  deaa_pkg::op_t                    op;
  logic [deaa_pkg::DATA_W-1:0]      req_bytes;
  logic [deaa_pkg::ALIGN_W-1:0]     align_log2;

  modport source (output valid, output op, output req_bytes, output align_log2,
                  input ready);
  modport sink (input valid, input op, input req_bytes, input align_log2,
                output ready);
endinterface

interface deaa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [deaa_pkg::DATA_W-1:0] offset;
  logic [deaa_pkg::DATA_W-1:0] low_used;
  logic [deaa_pkg::DATA_W-1:0] high_used;
  logic [deaa_pkg::DATA_W-1:0] peak_used;

  modport source (output valid, output ok, output offset, output low_used,
                  output high_used, output peak_used, input ready);
  modport sink (input valid, input ok, input offset, input low_used,
                input high_used, input peak_used, output ready);
endinterface
`default_nettype wire

// ===== design/deaa_step.sv =====
`default_nettype none
module deaa_step (
  input  wire deaa_pkg::op_t                op,
  input  wire logic [deaa_pkg::DATA_W-1:0]  req_bytes,
  input  wire logic [deaa_pkg::ALIGN_W-1:0] align_log2,
  input  wire logic [deaa_pkg::DATA_W-1:0]  cap,
  input  wire deaa_pkg::cursors_t           cur,
  output deaa_pkg::step_res_t               res
);
  import deaa_pkg::*;

  logic [CALC_W-1:0] low_e, high_e, cap_e, bytes_e, amask, used;
  logic [CALC_W-1:0] lo_start, lo_end, top, hi_start, new_sum;
  logic              nonzero, lo_fits, hi_fits;
  cursors_t          nxt;

  always_comb begin
    low_e   = CALC_W'(cur.low);
    high_e  = CALC_W'(cur.high);
    cap_e   = CALC_W'(cap);
    bytes_e = CALC_W'(req_bytes);
    amask   = (CALC_W'(1) << align_log2) - CALC_W'(1);
    nonzero = (req_bytes != '0);
    used    = low_e + high_e;

    // low end: round start up
    lo_start = (low_e + amask) & ~amask;
    lo_end   = lo_start + bytes_e;
    lo_fits  = nonzero && (high_e <= cap_e) && (lo_end <= cap_e - high_e);

    // high end: round start down, must not cross the low cursor
    top      = cap_e - high_e;
    hi_start = (top - bytes_e) & ~amask;
    hi_fits  = nonzero && (used <= cap_e) && (bytes_e <= cap_e - used) &&
               (hi_start >= low_e);

    nxt        = cur;
    res.ok     = 1'b0;
    res.offset = '0;
    case (op)
      OP_ALLOC_LOW: begin
        if (lo_fits) begin
          nxt.low    = lo_end[DATA_W-1:0];
          res.ok     = 1'b1;
          res.offset = lo_start[DATA_W-1:0];
        end
      end
      OP_ALLOC_HIGH: begin
        if (hi_fits) begin
          nxt.high   = DATA_W'(cap_e - hi_start);
          res.ok     = 1'b1;
          res.offset = hi_start[DATA_W-1:0];
        end
      end
      OP_RESET_ALL: begin
        nxt.low  = '0;
        nxt.high = '0;
        res.ok   = 1'b1;
      end
      OP_RESET_HIGH: begin
        nxt.high = '0;
        res.ok   = 1'b1;
      end
      default: begin
        nxt = cur;
      end
    endcase

    // peak mark moves only on a granted block and survives resets
    new_sum = CALC_W'(nxt.low) + CALC_W'(nxt.high);
    if ((op == OP_ALLOC_LOW || op == OP_ALLOC_HIGH) && res.ok &&
        new_sum > CALC_W'(cur.peak)) begin
      nxt.peak = new_sum[DATA_W-1:0];
    end
    res.cur = nxt;
  end

endmodule
`default_nettype wire

// ===== design/double_ended_arena_allocator_top.sv =====
`default_nettype none
// channel   dir  payload                                          transfer when
// req       in   op, req_bytes, align_log2                        valid && ready
// rsp       out  ok, offset, low_used, high_used, peak_used       valid && ready
// cfg       in   cfg_wdata (capacity)                             cfg_we
//
// one request per cycle while rsp is not stalled; a request reaches rsp through
// the input register, then the result register where the cursors update
// the cursor update is a single pass of adds, masks and compares on the
// registered request, so a following request sees the new cursors at once
// rst clears cursors, peak mark, capacity (to 1 MiB) and both valid flags
// a stalled rsp holds the result; req stays ready while the input register
// is empty or its request moves on in the same cycle
module double_ended_arena_allocator_top #(
  parameter int ADDR_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [deaa_pkg::DATA_W-1:0] cfg_wdata,
  deaa_req_if.sink                         req,
  deaa_rsp_if.source                       rsp
);
  import deaa_pkg::*;

  logic [DATA_W-1:0]  capacity;
  logic [DATA_W-1:0]  cap;
  cursors_t           cur;
  step_res_t          res;
  logic               s_valid;
  op_t                s_op;
  logic [DATA_W-1:0]  s_bytes;
  logic [ALIGN_W-1:0] s_align;
  logic               o_valid;
  logic               advance;

  generate
    if (ADDR_BITS >= DATA_W) begin : g_no_clamp
      assign cap = capacity;
    end else begin : g_clamp
      localparam logic [DATA_W-1:0] Lim = DATA_W'(1) << ADDR_BITS;
      assign cap = (capacity < Lim) ? capacity : Lim;
    end
  endgenerate

  assign advance   = s_valid && (!o_valid || rsp.ready);
  assign req.ready = !s_valid || advance;
  assign rsp.valid = o_valid;

  deaa_step u_step (
    .op         (s_op),
    .req_bytes  (s_bytes),
    .align_log2 (s_align),
    .cap        (cap),
    .cur        (cur),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.ready) begin
      s_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s_op    <= req.op;
      s_bytes <= req.req_bytes;
      s_align <= req.align_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (advance) begin
        cur     <= res.cur;
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.ok        <= res.ok;
      rsp.offset    <= res.offset;
      rsp.low_used  <= res.cur.low;
      rsp.high_used <= res.cur.high;
      rsp.peak_used <= res.cur.peak;
    end
  end

endmodule
`default_nettype wire

// ===== design/deaa_checker.sv =====
`default_nettype none
module deaa_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic                        rsp_ok,
  input wire logic [deaa_pkg::DATA_W-1:0] rsp_offset,
  input wire logic [deaa_pkg::DATA_W-1:0] rsp_low_used,
  input wire logic [deaa_pkg::DATA_W-1:0] rsp_high_used,
  input wire logic [deaa_pkg::DATA_W-1:0] rsp_peak_used
);
  import deaa_pkg::*;

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset) &&
    $stable(rsp_peak_used))
    else $error("rsp changed while stalled");

  a_refused_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_offset == '0)
    else $error("refused request carries an offset");

  // peak mark never below combined use
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CALC_W'(rsp_low_used) + CALC_W'(rsp_high_used)) <=
    CALC_W'(rsp_peak_used))
    else $error("combined use above peak mark");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind double_ended_arena_allocator_top deaa_checker u_deaa_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_ok        (rsp.ok),
  .rsp_offset    (rsp.offset),
  .rsp_low_used  (rsp.low_used),
  .rsp_high_used (rsp.high_used),
  .rsp_peak_used (rsp.peak_used)
);
`default_nettype wire
